// File: rtl/ft12_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft12_pkg
// Shared types, register map and reset constants of the FT1.2 frame validator.
// ----------------------------------------------------------------------------
package ft12_pkg;

    // Default of the chunk length parameter
    localparam int MAX_CHUNK_DEF = 256;

    // Configuration port geometry
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_STATION_ADDRESS = 3'd0,
        REG_ADDRESS_BYTES   = 3'd1,
        REG_FIXED_START     = 3'd2,
        REG_VARIABLE_START  = 3'd3,
        REG_STOP            = 3'd4
    } reg_idx_t;

    // Register reset values
    localparam logic [15:0] STATION_ADDRESS_RST = 16'h0000;
    localparam logic [1:0]  ADDRESS_BYTES_RST   = 2'd1;
    localparam logic [7:0]  FIXED_START_RST     = 8'h10;
    localparam logic [7:0]  VARIABLE_START_RST  = 8'h68;
    localparam logic [7:0]  STOP_RST            = 8'h16;

    // Frame kind codes
    localparam logic KIND_FIXED    = 1'b0;
    localparam logic KIND_VARIABLE = 1'b1;

    // Configuration seen by the checker
    typedef struct packed {
        logic [15:0] station_address;
        logic [1:0]  address_bytes;
        logic [7:0]  fixed_start_octet;
        logic [7:0]  variable_start_octet;
        logic [7:0]  stop_octet;
    } cfg_t;

    // Verdict for one chunk
    typedef struct packed {
        logic       frame_valid;
        logic       frame_kind;
        logic [7:0] control_octet;
    } verdict_t;

endpackage : ft12_pkg
`default_nettype wire

// File: rtl/ft12_rx_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft12_rx_if
// Received-byte channel: one octet per transaction, chunk end flag.
// ----------------------------------------------------------------------------
interface ft12_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_octet;
    logic       chunk_last;

    modport source (output valid, output rx_octet, output chunk_last, input ready);
    modport sink   (input valid, input rx_octet, input chunk_last, output ready);
endinterface : ft12_rx_if
`default_nettype wire

// File: rtl/ft12_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft12_res_if
// Verdict channel: one transaction per received chunk.
// ----------------------------------------------------------------------------
interface ft12_res_if;
    logic       valid;
    logic       ready;
    logic       frame_valid;
    logic       frame_kind;
    logic [7:0] control_octet;

    modport source (output valid, output frame_valid, output frame_kind,
                    output control_octet, input ready);
    modport sink   (input valid, input frame_valid, input frame_kind,
                    input control_octet, output ready);
endinterface : ft12_res_if
`default_nettype wire

// File: rtl/ft12_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft12_cfg_regs
// APB-style register file holding the link address and frame octets.
// ----------------------------------------------------------------------------
module ft12_cfg_regs
    import ft12_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // Decode register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_STATION_ADDRESS: cfg_next.station_address      = pwdata[15:0];
                REG_ADDRESS_BYTES:   cfg_next.address_bytes        = pwdata[1:0];
                REG_FIXED_START:     cfg_next.fixed_start_octet    = pwdata[7:0];
                REG_VARIABLE_START:  cfg_next.variable_start_octet = pwdata[7:0];
                REG_STOP:            cfg_next.stop_octet           = pwdata[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Read back selected register
    always_comb
    begin
        case (idx)
            REG_STATION_ADDRESS: prdata = {16'h0000, cfg_reg.station_address};
            REG_ADDRESS_BYTES:   prdata = {30'h0, cfg_reg.address_bytes};
            REG_FIXED_START:     prdata = {24'h0, cfg_reg.fixed_start_octet};
            REG_VARIABLE_START:  prdata = {24'h0, cfg_reg.variable_start_octet};
            REG_STOP:            prdata = {24'h0, cfg_reg.stop_octet};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.station_address      <= STATION_ADDRESS_RST;
            cfg_reg.address_bytes        <= ADDRESS_BYTES_RST;
            cfg_reg.fixed_start_octet    <= FIXED_START_RST;
            cfg_reg.variable_start_octet <= VARIABLE_START_RST;
            cfg_reg.stop_octet           <= STOP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule : ft12_cfg_regs
`default_nettype wire

// File: rtl/ft12_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ft12_check
// Per-chunk frame state: tracks fixed and variable layouts byte by byte and
// forms the verdict on the chunk's last byte.
// ----------------------------------------------------------------------------
module ft12_check
    import ft12_pkg::*;
#(
    parameter int MAX_CHUNK = MAX_CHUNK_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       advance,
    input  wire logic [7:0] octet,
    input  wire logic       last,
    output verdict_t        verdict
);

    localparam int POS_W = $clog2(MAX_CHUNK + 1);
    localparam int CMP_W = (POS_W > 10) ? POS_W : 10;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHUNK);

    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [7:0]       len_reg,   len_next;
    logic             len_ok_reg, len_ok_next;
    logic [7:0]       f_sum_reg,  f_sum_next;
    logic [7:0]       v_sum_reg,  v_sum_next;
    logic [15:0]      f_addr_reg, f_addr_next;
    logic [15:0]      v_addr_reg, v_addr_next;
    logic [7:0]       f_ctrl_reg, f_ctrl_next;
    logic [7:0]       v_ctrl_reg, v_ctrl_next;
    logic             f_pass_reg, f_pass_next;
    logic             v_pass_reg, v_pass_next;

    logic             active;
    logic [CMP_W-1:0] p;
    logic [CMP_W-1:0] lw;
    logic [CMP_W-1:0] len_w;
    logic [CMP_W-1:0] count;
    logic [7:0]       ctrl;
    logic             kind;

    assign active = (pos_reg < POS_MAX);
    assign p      = CMP_W'(pos_reg);
    assign lw     = (cfg.address_bytes >= 2'd2) ? CMP_W'(2) : CMP_W'(1);
    assign len_w  = CMP_W'(len_reg);

    // Advance both layouts with the current byte
    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        len_ok_next = len_ok_reg;
        f_sum_next  = f_sum_reg;
        v_sum_next  = v_sum_reg;
        f_addr_next = f_addr_reg;
        v_addr_next = v_addr_reg;
        f_ctrl_next = f_ctrl_reg;
        v_ctrl_next = v_ctrl_reg;
        f_pass_next = f_pass_reg;
        v_pass_next = v_pass_reg;
        if (active)
        begin
            pos_next = pos_reg + POS_W'(1);

            // Fixed layout
            if (p == CMP_W'(0) && octet != cfg.fixed_start_octet)
                f_pass_next = 1'b0;
            if (p >= CMP_W'(1) && p <= CMP_W'(1) + lw)
                f_sum_next = f_sum_reg + octet;
            if (p == CMP_W'(1))
                f_ctrl_next = octet;
            if (p >= CMP_W'(2) && p < CMP_W'(2) + lw)
            begin
                if (p == CMP_W'(2))
                    f_addr_next = f_addr_reg | {8'h00, octet};
                else
                    f_addr_next = f_addr_reg | {octet, 8'h00};
            end
            if (p == CMP_W'(2) + lw && octet != f_sum_reg)
                f_pass_next = 1'b0;
            if (p == CMP_W'(3) + lw && octet != cfg.stop_octet)
                f_pass_next = 1'b0;

            // Variable layout
            if (p == CMP_W'(0) && octet != cfg.variable_start_octet)
                v_pass_next = 1'b0;
            if (p == CMP_W'(1))
                len_next = octet;
            if (p == CMP_W'(2))
                len_ok_next = (octet == len_reg);
            if (p == CMP_W'(3) && octet != cfg.variable_start_octet)
                v_pass_next = 1'b0;
            if (p == CMP_W'(4))
                v_ctrl_next = octet;
            if (p >= CMP_W'(4) && p < CMP_W'(4) + len_w)
                v_sum_next = v_sum_reg + octet;
            if (p >= CMP_W'(5) && p < CMP_W'(5) + lw)
            begin
                if (p == CMP_W'(5))
                    v_addr_next = v_addr_reg | {8'h00, octet};
                else
                    v_addr_next = v_addr_reg | {octet, 8'h00};
            end
            if (p >= CMP_W'(4) && p == CMP_W'(4) + len_w && octet != v_sum_reg)
                v_pass_next = 1'b0;
            if (p >= CMP_W'(5) && p == CMP_W'(5) + len_w && octet != cfg.stop_octet)
                v_pass_next = 1'b0;
        end
    end

    // Form the verdict from the updated state; fixed frame wins
    always_comb
    begin
        count = CMP_W'(pos_next);
        ctrl  = 8'h00;
        kind  = KIND_FIXED;
        if (f_pass_next && count >= CMP_W'(4) + lw &&
            f_addr_next == cfg.station_address)
        begin
            ctrl = f_ctrl_next;
            kind = KIND_FIXED;
        end
        else if (v_pass_next && len_ok_next &&
                 count >= CMP_W'(6) + CMP_W'(len_next) &&
                 v_addr_next == cfg.station_address)
        begin
            ctrl = v_ctrl_next;
            kind = KIND_VARIABLE;
        end
        // Zero control counts as no frame
        verdict.frame_valid   = (ctrl != 8'h00);
        verdict.frame_kind    = (ctrl != 8'h00) ? kind : KIND_FIXED;
        verdict.control_octet = ctrl;
    end

    // Commit state; clear at chunk end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            len_ok_reg <= 1'b0;
            f_sum_reg  <= '0;
            v_sum_reg  <= '0;
            f_addr_reg <= '0;
            v_addr_reg <= '0;
            f_ctrl_reg <= '0;
            v_ctrl_reg <= '0;
            f_pass_reg <= 1'b1;
            v_pass_reg <= 1'b1;
        end
        else if (advance)
        begin
            if (last)
            begin
                pos_reg    <= '0;
                len_reg    <= '0;
                len_ok_reg <= 1'b0;
                f_sum_reg  <= '0;
                v_sum_reg  <= '0;
                f_addr_reg <= '0;
                v_addr_reg <= '0;
                f_ctrl_reg <= '0;
                v_ctrl_reg <= '0;
                f_pass_reg <= 1'b1;
                v_pass_reg <= 1'b1;
            end
            else
            begin
                pos_reg    <= pos_next;
                len_reg    <= len_next;
                len_ok_reg <= len_ok_next;
                f_sum_reg  <= f_sum_next;
                v_sum_reg  <= v_sum_next;
                f_addr_reg <= f_addr_next;
                v_addr_reg <= v_addr_next;
                f_ctrl_reg <= f_ctrl_next;
                v_ctrl_reg <= v_ctrl_next;
                f_pass_reg <= f_pass_next;
                v_pass_reg <= v_pass_next;
            end
        end
    end

endmodule : ft12_check
`default_nettype wire

// File: rtl/ft12_frame_validator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one byte per cycle, except that a chunk's last byte waits while
// the output register is full and unread; the input register feeds the frame
// checker, whose verdict lands in an output register that holds until taken.
// Reset: rst_n clears the pipeline valids and per-chunk state and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ft12_frame_validator_unit
// Top level of the FT1.2 fixed/variable frame validator.
// ----------------------------------------------------------------------------
module ft12_frame_validator_unit
    import ft12_pkg::*;
#(
    parameter int MAX_CHUNK = MAX_CHUNK_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    ft12_rx_if.sink                 rx_ch,
    ft12_res_if.source              res_ch
);

    cfg_t       cfg;
    verdict_t   verdict;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_octet_reg;
    logic       s1_last_reg;
    logic       s1_adv;
    logic       rx_take;

    logic       out_valid_reg, out_valid_next;
    verdict_t   out_data_reg;
    logic       out_load;

    ft12_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ft12_check #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (s1_adv),
        .octet   (s1_octet_reg),
        .last    (s1_last_reg),
        .verdict (verdict)
    );

    // Advance the staged byte unless its verdict has nowhere to go
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || res_ch.ready);
    assign rx_take  = rx_ch.valid && rx_ch.ready;
    assign out_load = s1_adv && s1_last_reg;

    assign rx_ch.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rx_ch.ready)
            s1_valid_next = rx_ch.valid;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (res_ch.ready)
            out_valid_next = 1'b0;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            s1_octet_reg <= rx_ch.rx_octet;
            s1_last_reg  <= rx_ch.chunk_last;
        end
        if (out_load)
            out_data_reg <= verdict;
    end

    assign res_ch.valid         = out_valid_reg;
    assign res_ch.frame_valid   = out_data_reg.frame_valid;
    assign res_ch.frame_kind    = out_data_reg.frame_kind;
    assign res_ch.control_octet = out_data_reg.control_octet;

endmodule : ft12_frame_validator_unit
`default_nettype wire
